### rtl/assert_macros.svh
// Assertion helpers for the RTL files; pla_ctrl.sv is the one that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLA_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/pla_pkg.sv
package pla_pkg;

    localparam int unsigned POS_W    = 32;
    localparam int unsigned QUAT_W   = 16;
    localparam int unsigned STAMP_W  = 48;
    localparam int unsigned OFF_W    = 21;
    localparam int unsigned IV_W     = 32;
    localparam int unsigned SQ_W     = 32;
    localparam int unsigned MA_W     = 34;
    localparam int unsigned PROD_W   = MA_W + OFF_W;
    localparam int unsigned ACC_W    = 56;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned Q_STEPS  = 16;
    localparam int unsigned SQ_STEPS = 10;
    localparam int unsigned Q_FRAC   = 15;
    localparam int unsigned ROT_FRAC = 30;

    localparam logic signed [ACC_W-1:0] Q_BIAS   = ACC_W'(2 ** (Q_FRAC - 1));
    localparam logic signed [ACC_W-1:0] ROT_BIAS = ACC_W'(2 ** (ROT_FRAC - 1));

    // Quaternion component positions.
    localparam logic [1:0] C_X = 2'd0;
    localparam logic [1:0] C_Y = 2'd1;
    localparam logic [1:0] C_Z = 2'd2;
    localparam logic [1:0] C_W = 2'd3;

    localparam logic [1:0] COL_LAST = 2'd2;
    localparam logic [1:0] ROW_LAST = 2'd2;

    // Positions of the stored products of the relative quaternion.
    localparam logic [IDX_W-1:0] SQ_XX = 4'd0;
    localparam logic [IDX_W-1:0] SQ_YY = 4'd1;
    localparam logic [IDX_W-1:0] SQ_ZZ = 4'd2;
    localparam logic [IDX_W-1:0] SQ_WW = 4'd3;
    localparam logic [IDX_W-1:0] SQ_XY = 4'd4;
    localparam logic [IDX_W-1:0] SQ_XZ = 4'd5;
    localparam logic [IDX_W-1:0] SQ_YZ = 4'd6;
    localparam logic [IDX_W-1:0] SQ_WX = 4'd7;
    localparam logic [IDX_W-1:0] SQ_WY = 4'd8;
    localparam logic [IDX_W-1:0] SQ_WZ = 4'd9;

    typedef enum logic [1:0] {
        REG_OFF_X,
        REG_OFF_Y,
        REG_OFF_Z,
        REG_MIN_IV
    } t_reg_idx;

    typedef enum logic [1:0] {
        K_NONE,
        K_Q,
        K_SQ,
        K_M
    } t_kind;

    typedef struct packed {
        logic             load;
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        logic             form;
        logic             pub;
    } t_cmd;

    typedef struct packed {
        logic signed [OFF_W-1:0] off_x;
        logic signed [OFF_W-1:0] off_y;
        logic signed [OFF_W-1:0] off_z;
        logic [IV_W-1:0]         min_iv;
    } t_cfg;

    typedef struct packed {
        logic [1:0] in_i;
        logic [1:0] ref_i;
        logic       neg;
    } t_qterm;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
    } t_pair;

    // Terms of q times the conjugate of the reference, index {component, term}.
    function automatic t_qterm q_term(input logic [IDX_W-1:0] k);
        t_qterm t;
        case (k)
            4'd0:    t = '{C_W, C_X, 1'b1};
            4'd1:    t = '{C_X, C_W, 1'b0};
            4'd2:    t = '{C_Y, C_Z, 1'b1};
            4'd3:    t = '{C_Z, C_Y, 1'b0};
            4'd4:    t = '{C_W, C_Y, 1'b1};
            4'd5:    t = '{C_X, C_Z, 1'b0};
            4'd6:    t = '{C_Y, C_W, 1'b0};
            4'd7:    t = '{C_Z, C_X, 1'b1};
            4'd8:    t = '{C_W, C_Z, 1'b1};
            4'd9:    t = '{C_X, C_Y, 1'b1};
            4'd10:   t = '{C_Y, C_X, 1'b0};
            4'd11:   t = '{C_Z, C_W, 1'b0};
            4'd12:   t = '{C_W, C_W, 1'b0};
            4'd13:   t = '{C_X, C_X, 1'b0};
            4'd14:   t = '{C_Y, C_Y, 1'b0};
            4'd15:   t = '{C_Z, C_Z, 1'b0};
            default: t = '{C_W, C_W, 1'b0};
        endcase
        return t;
    endfunction

    function automatic t_pair sq_pair(input logic [IDX_W-1:0] k);
        t_pair p;
        case (k)
            SQ_XX:   p = '{C_X, C_X};
            SQ_YY:   p = '{C_Y, C_Y};
            SQ_ZZ:   p = '{C_Z, C_Z};
            SQ_WW:   p = '{C_W, C_W};
            SQ_XY:   p = '{C_X, C_Y};
            SQ_XZ:   p = '{C_X, C_Z};
            SQ_YZ:   p = '{C_Y, C_Z};
            SQ_WX:   p = '{C_W, C_X};
            SQ_WY:   p = '{C_W, C_Y};
            SQ_WZ:   p = '{C_W, C_Z};
            default: p = '{C_X, C_X};
        endcase
        return p;
    endfunction

endpackage

### rtl/pla_regs.sv
module pla_regs
    import pla_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic signed [OFF_W-1:0] r_off_x;
    logic signed [OFF_W-1:0] r_off_y;
    logic signed [OFF_W-1:0] r_off_z;
    logic [IV_W-1:0]         r_min_iv;
    t_reg_idx                sel;
    logic                    wr_en;

    assign sel    = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_off_z  <= '0;
            r_min_iv <= '0;
        end else if (wr_en) begin
            case (sel)
                REG_OFF_X:  r_off_x  <= pwdata[OFF_W-1:0];
                REG_OFF_Y:  r_off_y  <= pwdata[OFF_W-1:0];
                REG_OFF_Z:  r_off_z  <= pwdata[OFF_W-1:0];
                REG_MIN_IV: r_min_iv <= pwdata[IV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_OFF_X:  prdata = {{(PDATA_W-OFF_W){r_off_x[OFF_W-1]}}, r_off_x};
            REG_OFF_Y:  prdata = {{(PDATA_W-OFF_W){r_off_y[OFF_W-1]}}, r_off_y};
            REG_OFF_Z:  prdata = {{(PDATA_W-OFF_W){r_off_z[OFF_W-1]}}, r_off_z};
            REG_MIN_IV: prdata = r_min_iv;
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = '{r_off_x, r_off_y, r_off_z, r_min_iv};

endmodule

### rtl/pla_dp.sv
module pla_dp
    import pla_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  t_cfg                     i_cfg,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic signed [QUAT_W-1:0] i_quat_x,
    input  logic signed [QUAT_W-1:0] i_quat_y,
    input  logic signed [QUAT_W-1:0] i_quat_z,
    input  logic signed [QUAT_W-1:0] i_quat_w,
    input  logic [STAMP_W-1:0]       i_stamp,
    output logic signed [POS_W-1:0]  o_com_x,
    output logic signed [POS_W-1:0]  o_com_y,
    output logic signed [POS_W-1:0]  o_com_z,
    output logic signed [QUAT_W-1:0] o_rel_x,
    output logic signed [QUAT_W-1:0] o_rel_y,
    output logic signed [QUAT_W-1:0] o_rel_z,
    output logic signed [QUAT_W-1:0] o_rel_w,
    output logic                     o_forward
);

    localparam logic [1:0] Q_TERM_LAST = 2'd3;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        logic             neg;
    } t_pipe;

    function automatic logic signed [MA_W-1:0] ext_sq(input logic signed [SQ_W-1:0] v);
        return {{(MA_W-SQ_W){v[SQ_W-1]}}, v};
    endfunction

    function automatic logic signed [QUAT_W-1:0] sat_rel(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        logic [ACC_W-QUAT_W:0]   hi;
        s  = v >>> Q_FRAC;
        hi = s[ACC_W-1:QUAT_W-1];
        if ((&hi) || !(|hi)) begin
            return s[QUAT_W-1:0];
        end else if (s[ACC_W-1]) begin
            return {1'b1, {(QUAT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(QUAT_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [POS_W-1:0] add_sat(input logic signed [POS_W-1:0] p,
                                                        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        logic signed [POS_W:0]   sum;
        s   = v >>> ROT_FRAC;
        sum = {p[POS_W-1], p} + s[POS_W:0];
        if (sum[POS_W] == sum[POS_W-1]) begin
            return sum[POS_W-1:0];
        end else if (sum[POS_W]) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

    logic signed [POS_W-1:0]  r_pos [3];
    logic signed [QUAT_W-1:0] r_q1 [4];
    logic signed [QUAT_W-1:0] r_ref [4];
    logic                     r_await;
    logic [STAMP_W-1:0]       r_last;
    logic                     r_fwd;
    logic signed [QUAT_W-1:0] r_rel [4];
    logic signed [SQ_W-1:0]   r_sq [SQ_STEPS];
    logic signed [MA_W-1:0]   r_ma;
    logic signed [PROD_W-1:0] r_prod;
    t_pipe                    r_p;
    logic signed [ACC_W-1:0]  r_acc;
    t_pipe                    r_a;
    logic signed [POS_W-1:0]  r_com [3];
    logic signed [POS_W-1:0]  r_o_com [3];
    logic signed [QUAT_W-1:0] r_o_rel [4];
    logic                     r_o_fwd;

    logic [STAMP_W-1:0]       gap;
    logic                     fwd_now;
    t_qterm                   qt;
    t_pair                    sp;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [OFF_W-1:0]  mul_b;
    logic                     mul_neg;
    logic signed [MA_W-1:0]   n_ma;
    logic signed [ACC_W-1:0]  p_ext;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     p_last;

    assign gap     = i_stamp - r_last;
    assign fwd_now = (i_stamp > r_last) && (gap > {{(STAMP_W-IV_W){1'b0}}, i_cfg.min_iv});

    // Input capture, reference orientation and rate limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b1;
            r_last  <= '0;
            r_ref   <= '{default: '0};
        end else if (i_cmd.load) begin
            if (fwd_now) begin
                r_last <= i_stamp;
            end
            if (r_await) begin
                r_ref   <= '{i_quat_x, i_quat_y, i_quat_z, i_quat_w};
                r_await <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos <= '{i_pos_x, i_pos_y, i_pos_z};
            r_q1  <= '{i_quat_x, i_quat_y, i_quat_z, i_quat_w};
            r_fwd <= fwd_now;
        end
    end

    // Rotation matrix entry for {row, col}.
    always_comb begin
        case (i_cmd.idx)
            {2'd0, 2'd0}: n_ma = ext_sq(r_sq[SQ_WW]) + ext_sq(r_sq[SQ_XX])
                                 - ext_sq(r_sq[SQ_YY]) - ext_sq(r_sq[SQ_ZZ]);
            {2'd0, 2'd1}: n_ma = (ext_sq(r_sq[SQ_XY]) - ext_sq(r_sq[SQ_WZ])) <<< 1;
            {2'd0, 2'd2}: n_ma = (ext_sq(r_sq[SQ_XZ]) + ext_sq(r_sq[SQ_WY])) <<< 1;
            {2'd1, 2'd0}: n_ma = (ext_sq(r_sq[SQ_XY]) + ext_sq(r_sq[SQ_WZ])) <<< 1;
            {2'd1, 2'd1}: n_ma = ext_sq(r_sq[SQ_WW]) - ext_sq(r_sq[SQ_XX])
                                 + ext_sq(r_sq[SQ_YY]) - ext_sq(r_sq[SQ_ZZ]);
            {2'd1, 2'd2}: n_ma = (ext_sq(r_sq[SQ_YZ]) - ext_sq(r_sq[SQ_WX])) <<< 1;
            {2'd2, 2'd0}: n_ma = (ext_sq(r_sq[SQ_XZ]) - ext_sq(r_sq[SQ_WY])) <<< 1;
            {2'd2, 2'd1}: n_ma = (ext_sq(r_sq[SQ_YZ]) + ext_sq(r_sq[SQ_WX])) <<< 1;
            {2'd2, 2'd2}: n_ma = ext_sq(r_sq[SQ_WW]) - ext_sq(r_sq[SQ_XX])
                                 - ext_sq(r_sq[SQ_YY]) + ext_sq(r_sq[SQ_ZZ]);
            default:      n_ma = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.form) begin
            r_ma <= n_ma;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        qt      = q_term(i_cmd.idx);
        sp      = sq_pair(i_cmd.idx);
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (i_cmd.kind)
            K_Q: begin
                mul_a   = {{(MA_W-QUAT_W){r_q1[qt.in_i][QUAT_W-1]}}, r_q1[qt.in_i]};
                mul_b   = {{(OFF_W-QUAT_W){r_ref[qt.ref_i][QUAT_W-1]}}, r_ref[qt.ref_i]};
                mul_neg = qt.neg;
            end
            K_SQ: begin
                mul_a = {{(MA_W-QUAT_W){r_rel[sp.a][QUAT_W-1]}}, r_rel[sp.a]};
                mul_b = {{(OFF_W-QUAT_W){r_rel[sp.b][QUAT_W-1]}}, r_rel[sp.b]};
            end
            K_M: begin
                mul_a = r_ma;
                case (i_cmd.idx[1:0])
                    2'd0:    mul_b = i_cfg.off_x;
                    2'd1:    mul_b = i_cfg.off_y;
                    default: mul_b = i_cfg.off_z;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Accumulation of signed products onto the rounding bias.
    always_comb begin
        p_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        if (r_p.kind == K_Q) begin
            base   = (r_p.idx[1:0] == 2'd0) ? Q_BIAS : r_acc;
            p_last = (r_p.idx[1:0] == Q_TERM_LAST);
        end else begin
            base   = (r_p.idx[1:0] == 2'd0) ? ROT_BIAS : r_acc;
            p_last = (r_p.idx[1:0] == COL_LAST);
        end
        n_acc = r_p.neg ? (base - p_ext) : (base + p_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
            r_a <= '0;
        end else begin
            r_p <= '{i_cmd.kind != K_NONE, i_cmd.kind, i_cmd.idx, mul_neg};
            r_a <= '{r_p.valid && (r_p.kind != K_SQ) && p_last, r_p.kind, r_p.idx, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p.valid) begin
            if (r_p.kind == K_SQ) begin
                r_sq[r_p.idx] <= r_prod[SQ_W-1:0];
            end else begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a.valid) begin
            if (r_a.kind == K_Q) begin
                r_rel[r_a.idx[3:2]] <= sat_rel(r_acc);
            end else begin
                r_com[r_a.idx[3:2]] <= add_sat(r_pos[r_a.idx[3:2]], r_acc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pub) begin
            r_o_com <= r_com;
            r_o_rel <= r_rel;
            r_o_fwd <= r_fwd;
        end
    end

    assign o_com_x   = r_o_com[0];
    assign o_com_y   = r_o_com[1];
    assign o_com_z   = r_o_com[2];
    assign o_rel_x   = r_o_rel[C_X];
    assign o_rel_y   = r_o_rel[C_Y];
    assign o_rel_z   = r_o_rel[C_Z];
    assign o_rel_w   = r_o_rel[C_W];
    assign o_forward = r_o_fwd;

endmodule

### rtl/pla_ctrl.sv
`include "assert_macros.svh"

module pla_ctrl
    import pla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    localparam int unsigned Q_DRAIN = 2;
    localparam int unsigned M_DRAIN = 2;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_QMUL  = 9'b000000010,
        S_QWAIT = 9'b000000100,
        S_SQ    = 9'b000001000,
        S_SWAIT = 9'b000010000,
        S_MFORM = 9'b000100000,
        S_MMUL  = 9'b001000000,
        S_MWAIT = 9'b010000000,
        S_PUB   = 9'b100000000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_cnt;
    logic             r_ovalid;
    logic             n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        o_cmd    = '{1'b0, K_NONE, r_cnt, 1'b0, 1'b0};
        n_ovalid = r_ovalid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_QMUL;
                end
            end
            S_QMUL: begin
                o_cmd.kind = K_Q;
                if (r_cnt == IDX_W'(Q_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_QWAIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_QWAIT: begin
                if (r_cnt == IDX_W'(Q_DRAIN - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SQ;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.kind = K_SQ;
                if (r_cnt == IDX_W'(SQ_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SWAIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SWAIT: begin
                n_cnt   = '0;
                n_state = S_MFORM;
            end
            S_MFORM: begin
                o_cmd.form = 1'b1;
                n_state    = S_MMUL;
            end
            S_MMUL: begin
                o_cmd.kind = K_M;
                if (r_cnt[3:2] == ROW_LAST && r_cnt[1:0] == COL_LAST) begin
                    n_cnt   = '0;
                    n_state = S_MWAIT;
                end else if (r_cnt[1:0] == COL_LAST) begin
                    n_cnt   = {r_cnt[3:2] + 2'd1, 2'd0};
                    n_state = S_MFORM;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_MFORM;
                end
            end
            S_MWAIT: begin
                if (r_cnt == IDX_W'(M_DRAIN - 1)) begin
                    n_cnt   = '0;
                    n_state = S_PUB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_PUB: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.pub = 1'b1;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    `PLA_ASSERT_NXT(a_start_qmul, i_clk, i_rst_n, i_valid && o_ready, r_state == S_QMUL, "accepted transfer did not start the quaternion product")
    `PLA_ASSERT_IMP(a_rose_after_pub, i_clk, i_rst_n, $rose(r_ovalid), $past(r_state == S_PUB), "result became valid outside the publish step")
    `PLA_ASSERT_IMP(a_mmul_range, i_clk, i_rst_n, r_state == S_MMUL, (r_cnt[1:0] != 2'd3) && (r_cnt[3:2] != 2'd3), "matrix step index out of range")

endmodule

### rtl/pose_lever_arm_offset.sv
// Pose lever-arm compensation.
// Input channel (i_valid / o_ready) carries one camera pose sample per transfer:
// Q16.16 position, Q1.15 orientation quaternion and a 48-bit microsecond stamp.
// Output channel (o_valid / i_ready) carries the center-of-mass position, the
// orientation relative to the first sample after reset, and the forward flag.
// The APB port holds the lever-arm offset and the minimum forward interval;
// write it only while no sample is in flight.
// A sample is accepted only while the block is idle. Its result becomes valid
// as the block returns to idle, and the next sample can be accepted in that
// same cycle; a new sample is never taken before the last one is finished.
// All products run in sequence on a single shared 34 x 21 multiplier: 16
// quaternion products, 10 squared terms and 9 matrix-by-offset products.
// The finished result sits in an output register; while the receiver stalls,
// the next sample is still taken and computed, and it waits for publication
// until the previous result has been transferred.
// Reset clears the offsets, the interval, the last forwarded stamp and the
// valid flags, and arms the capture of a new reference orientation.
module pose_lever_arm_offset
    import pla_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic signed [QUAT_W-1:0] i_quat_x,
    input  logic signed [QUAT_W-1:0] i_quat_y,
    input  logic signed [QUAT_W-1:0] i_quat_z,
    input  logic signed [QUAT_W-1:0] i_quat_w,
    input  logic [STAMP_W-1:0]       i_stamp,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [POS_W-1:0]  o_com_x,
    output logic signed [POS_W-1:0]  o_com_y,
    output logic signed [POS_W-1:0]  o_com_z,
    output logic signed [QUAT_W-1:0] o_rel_x,
    output logic signed [QUAT_W-1:0] o_rel_y,
    output logic signed [QUAT_W-1:0] o_rel_z,
    output logic signed [QUAT_W-1:0] o_rel_w,
    output logic                     o_forward
);

    t_cfg cfg;
    t_cmd cmd;

    pla_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    pla_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_cfg     (cfg),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_quat_x  (i_quat_x),
        .i_quat_y  (i_quat_y),
        .i_quat_z  (i_quat_z),
        .i_quat_w  (i_quat_w),
        .i_stamp   (i_stamp),
        .o_com_x   (o_com_x),
        .o_com_y   (o_com_y),
        .o_com_z   (o_com_z),
        .o_rel_x   (o_rel_x),
        .o_rel_y   (o_rel_y),
        .o_rel_z   (o_rel_z),
        .o_rel_w   (o_rel_w),
        .o_forward (o_forward)
    );

endmodule

### tb/pose_lever_arm_offset_test.sv
module pose_lever_arm_offset_test
    import pla_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     HOLD_CYCLES   = 600;
    localparam int     STALL_LIMIT   = 20000;
    localparam int     DRAIN_CYCLES  = 60;
    localparam int     PHASE_ITEMS   = 170;
    localparam longint COM_MAX       = 64'sd2147483647;
    localparam longint COM_MIN       = -64'sd2147483648;
    localparam longint LEVER_MAX     = 524288;
    localparam longint LEVER_MIN     = -524288;

    typedef struct {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic [STAMP_W-1:0]       stamp;
    } t_pose;

    typedef struct {
        logic signed [POS_W-1:0]  com_x;
        logic signed [POS_W-1:0]  com_y;
        logic signed [POS_W-1:0]  com_z;
        logic signed [QUAT_W-1:0] rel_x;
        logic signed [QUAT_W-1:0] rel_y;
        logic signed [QUAT_W-1:0] rel_z;
        logic signed [QUAT_W-1:0] rel_w;
        logic                     forward;
    } t_com_result;

    typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} t_rx_mode;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [POS_W-1:0]  i_pos_x = '0;
    logic signed [POS_W-1:0]  i_pos_y = '0;
    logic signed [POS_W-1:0]  i_pos_z = '0;
    logic signed [QUAT_W-1:0] i_quat_x = '0;
    logic signed [QUAT_W-1:0] i_quat_y = '0;
    logic signed [QUAT_W-1:0] i_quat_z = '0;
    logic signed [QUAT_W-1:0] i_quat_w = '0;
    logic [STAMP_W-1:0]       i_stamp = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [POS_W-1:0]  o_com_x;
    logic signed [POS_W-1:0]  o_com_y;
    logic signed [POS_W-1:0]  o_com_z;
    logic signed [QUAT_W-1:0] o_rel_x;
    logic signed [QUAT_W-1:0] o_rel_y;
    logic signed [QUAT_W-1:0] o_rel_z;
    logic signed [QUAT_W-1:0] o_rel_w;
    logic                     o_forward;

    // Shadow copy of the block's configuration and state.
    longint                   lever_x = 0;
    longint                   lever_y = 0;
    longint                   lever_z = 0;
    logic [IV_W-1:0]          min_gap = '0;
    logic signed [QUAT_W-1:0] ref_x = '0;
    logic signed [QUAT_W-1:0] ref_y = '0;
    logic signed [QUAT_W-1:0] ref_z = '0;
    logic signed [QUAT_W-1:0] ref_w = '0;
    bit                       ref_pending = 1'b1;
    logic [STAMP_W-1:0]       last_fwd_stamp = '0;

    t_com_result              pending_com[$];
    int                       errors = 0;
    int                       burst_left = 0;
    bit                       steady_feed = 1'b0;
    logic [STAMP_W-1:0]       stamp_now = '0;
    bit                       hold_request = 1'b0;
    int                       hold_left = 0;
    t_rx_mode                 rx_mode = RX_OPEN;
    int                       rx_seg_left = 0;
    int                       stall_cycles = 0;

    pose_lever_arm_offset dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_quat_x  (i_quat_x),
        .i_quat_y  (i_quat_y),
        .i_quat_z  (i_quat_z),
        .i_quat_w  (i_quat_w),
        .i_stamp   (i_stamp),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_com_x   (o_com_x),
        .o_com_y   (o_com_y),
        .o_com_z   (o_com_z),
        .o_rel_x   (o_rel_x),
        .o_rel_y   (o_rel_y),
        .o_rel_z   (o_rel_z),
        .o_rel_w   (o_rel_w),
        .o_forward (o_forward)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint round_q15(input longint s);
        longint v;
        v = (s + 64'sd16384) >>> Q_FRAC;
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return v;
    endfunction

    function automatic longint rotate_row(input longint a, input longint b, input longint c);
        return (a * lever_x + b * lever_y + c * lever_z + (64'sd1 <<< (ROT_FRAC - 1)))
            >>> ROT_FRAC;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > COM_MAX) begin
            v = COM_MAX;
        end else if (v < COM_MIN) begin
            v = COM_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    function automatic t_com_result predict_com(input t_pose p);
        longint      x1, y1, z1, w1, x2, y2, z2, w2;
        longint      rx, ry, rz, rw;
        longint      xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
        t_com_result r;
        x1 = p.quat_x;
        y1 = p.quat_y;
        z1 = p.quat_z;
        w1 = p.quat_w;
        if (ref_pending) begin
            ref_x = p.quat_x;
            ref_y = p.quat_y;
            ref_z = p.quat_z;
            ref_w = p.quat_w;
            ref_pending = 1'b0;
        end
        x2 = -longint'(ref_x);
        y2 = -longint'(ref_y);
        z2 = -longint'(ref_z);
        w2 = ref_w;

        rw = round_q15(w1 * w2 - x1 * x2 - y1 * y2 - z1 * z2);
        rx = round_q15(w1 * x2 + x1 * w2 + y1 * z2 - z1 * y2);
        ry = round_q15(w1 * y2 - x1 * z2 + y1 * w2 + z1 * x2);
        rz = round_q15(w1 * z2 + x1 * y2 - y1 * x2 + z1 * w2);

        xx = rx * rx; yy = ry * ry; zz = rz * rz; ww = rw * rw;
        xy = rx * ry; xz = rx * rz; yz = ry * rz;
        wx = rw * rx; wy = rw * ry; wz = rw * rz;

        r.com_x = clamp_pos(longint'(p.pos_x)
            + rotate_row(ww + xx - yy - zz, 2 * (xy - wz), 2 * (xz + wy)));
        r.com_y = clamp_pos(longint'(p.pos_y)
            + rotate_row(2 * (xy + wz), ww - xx + yy - zz, 2 * (yz - wx)));
        r.com_z = clamp_pos(longint'(p.pos_z)
            + rotate_row(2 * (xz - wy), 2 * (yz + wx), ww - xx - yy + zz));
        r.rel_x = rx[QUAT_W-1:0];
        r.rel_y = ry[QUAT_W-1:0];
        r.rel_z = rz[QUAT_W-1:0];
        r.rel_w = rw[QUAT_W-1:0];

        r.forward = (p.stamp > last_fwd_stamp)
            && (({16'd0, p.stamp} - {16'd0, last_fwd_stamp}) > {32'd0, min_gap});
        if (r.forward) begin
            last_fwd_stamp = p.stamp;
        end
        return r;
    endfunction

    function automatic t_pose make_pose(input longint px, input longint py, input longint pz,
                                        input longint qx, input longint qy, input longint qz,
                                        input longint qw, input longint st);
        t_pose p;
        p.pos_x  = px[POS_W-1:0];
        p.pos_y  = py[POS_W-1:0];
        p.pos_z  = pz[POS_W-1:0];
        p.quat_x = qx[QUAT_W-1:0];
        p.quat_y = qy[QUAT_W-1:0];
        p.quat_z = qz[QUAT_W-1:0];
        p.quat_w = qw[QUAT_W-1:0];
        p.stamp  = st[STAMP_W-1:0];
        return p;
    endfunction

    function automatic logic signed [POS_W-1:0] random_pos();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            return $urandom;
        end else if (sel < 90) begin
            return 32'h7fff_ffff - $urandom_range(0, 1 << 20);
        end
        return 32'h8000_0000 + $urandom_range(0, 1 << 20);
    endfunction

    function automatic logic signed [QUAT_W-1:0] edge_quat();
        case ($urandom_range(0, 6))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            4:       return 16'sh0001;
            5:       return 16'sd23170;
            default: return -16'sd23170;
        endcase
    endfunction

    function automatic t_pose random_pose();
        t_pose       p;
        int unsigned sel;
        longint      delta;
        p.pos_x = random_pos();
        p.pos_y = random_pos();
        p.pos_z = random_pos();
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            p.quat_x = 16'($urandom);
            p.quat_y = 16'($urandom);
            p.quat_z = 16'($urandom);
            p.quat_w = 16'($urandom);
        end else if (sel < 80) begin
            p.quat_x = edge_quat();
            p.quat_y = edge_quat();
            p.quat_z = edge_quat();
            p.quat_w = edge_quat();
        end else begin
            p.quat_x = 16'($signed($urandom_range(0, 4000)) - 2000);
            p.quat_y = 16'($signed($urandom_range(0, 4000)) - 2000);
            p.quat_z = 16'($signed($urandom_range(0, 4000)) - 2000);
            p.quat_w = 16'(32767 - $urandom_range(0, 3000));
        end

        // Some steps land near the rate threshold; others go back or jump far.
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            delta = longint'(min_gap) + longint'($urandom_range(0, 4)) - 2;
        end else if (sel < 55) begin
            delta = longint'($urandom_range(0, 64));
        end else if (sel < 75) begin
            delta = (longint'(min_gap) * longint'($urandom_range(0, 16))) / 8;
        end else if (sel < 85) begin
            delta = -longint'($urandom_range(0, 5000));
        end else if (sel < 95) begin
            delta = longint'($urandom);
        end else begin
            delta = longint'({$urandom, $urandom}) - longint'(stamp_now);
        end
        stamp_now = STAMP_W'(longint'(stamp_now) + delta);
        p.stamp = stamp_now;
        return p;
    endfunction

    task automatic send_pose(input t_pose p);
        int gap;
        if (!steady_feed && burst_left == 0) begin
            gap = $urandom_range(0, 120);
            burst_left = $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_valid  <= 1'b1;
        i_pos_x  <= p.pos_x;
        i_pos_y  <= p.pos_y;
        i_pos_z  <= p.pos_z;
        i_quat_x <= p.quat_x;
        i_quat_y <= p.quat_y;
        i_quat_z <= p.quat_z;
        i_quat_w <= p.quat_w;
        i_stamp  <= p.stamp;
        do @(posedge i_clk); while (!o_ready);
        pending_com.push_back(predict_com(p));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_com.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OFF_X:  lever_x = longint'($signed(value[OFF_W-1:0]));
            REG_OFF_Y:  lever_y = longint'($signed(value[OFF_W-1:0]));
            REG_OFF_Z:  lever_z = longint'($signed(value[OFF_W-1:0]));
            REG_MIN_IV: min_gap = value[IV_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic set_config(input longint ox, input longint oy, input longint oz,
                              input logic [IV_W-1:0] gap);
        write_reg(REG_OFF_X, PDATA_W'(ox));
        write_reg(REG_OFF_Y, PDATA_W'(oy));
        write_reg(REG_OFF_Z, PDATA_W'(oz));
        write_reg(REG_MIN_IV, gap);
    endtask

    function automatic longint random_lever();
        return longint'($urandom_range(0, 1048576)) - 524288;
    endfunction

    // The first sample after reset becomes the reference orientation.
    task automatic test_first_sample();
        set_config(98304, -16384, 131072, 500);
        send_pose(make_pose(65536, -131072, 2147418112, 4660, -8192, 2048, 28672, 1000));
        send_pose(make_pose(-5, 7, 0, 4660, -8192, 2048, 28672, 1000));
        wait_idle();
    endtask

    task automatic test_rate_limit();
        send_pose(make_pose(1000, 2000, 3000, 0, 0, 0, 32767, 1500));
        send_pose(make_pose(0, 0, 0, -12000, 5000, 20000, -15000, 1501));
        send_pose(make_pose(0, 0, 0, 0, 0, 0, 32767, 200));
        send_pose(make_pose(0, 0, 0, 32767, 0, 0, 0, 2002));
        wait_idle();
        write_reg(REG_MIN_IV, 32'hffff_ffff);
        send_pose(make_pose(0, 0, 0, 0, 32767, 0, 0, 2002 + 64'h0_ffff_ffff));
        send_pose(make_pose(0, 0, 0, 0, 0, 32767, 0, 2002 + 64'h1_0000_0000));
        send_pose(make_pose(0, 0, 0, 100, 200, 300, 400, 48'hffff_ffff_ffff));
        send_pose(make_pose(0, 0, 0, 100, 200, 300, 400, 0));
        wait_idle();
        write_reg(REG_MIN_IV, 0);
        send_pose(make_pose(0, 0, 0, 1, 1, 1, 1, 48'hffff_ffff_ffff));
        send_pose(make_pose(0, 0, 0, 1, 1, 1, 1, 48'hffff_ffff_fffe));
        wait_idle();
    endtask

    task automatic test_extremes();
        set_config(LEVER_MAX, LEVER_MAX, LEVER_MAX, 0);
        send_pose(make_pose(COM_MAX, COM_MAX, COM_MAX, 32767, 32767, 32767, 32767, 10));
        send_pose(make_pose(COM_MIN, COM_MIN, COM_MIN, -32768, -32768, -32768, -32768, 20));
        send_pose(make_pose(COM_MAX, COM_MIN, 0, 0, 0, 0, 0, 30));
        send_pose(make_pose(COM_MIN, COM_MAX, -1, -32768, 0, 0, 0, 40));
        wait_idle();
        set_config(LEVER_MIN, LEVER_MIN, LEVER_MIN, 1);
        send_pose(make_pose(COM_MIN, COM_MIN, COM_MIN, 32767, 32767, 32767, 32767, 50));
        send_pose(make_pose(COM_MAX, COM_MAX, COM_MAX, -32768, 32767, -32768, 32767, 51));
        send_pose(make_pose(COM_MIN, COM_MAX, COM_MIN, 0, -32768, 0, -32768, 53));
        send_pose(make_pose(-1, -1, -1, 0, 0, -32768, 0, 60));
        wait_idle();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(random_lever(), random_lever(), random_lever(),
                              $urandom_range(0, 2000));
                1: set_config(LEVER_MAX, LEVER_MAX, LEVER_MAX, 0);
                2: set_config(LEVER_MIN, LEVER_MIN, LEVER_MIN, 32'hffff_ffff);
                3: set_config(0, 0, 0, $urandom);
                4: set_config(random_lever(), random_lever(), random_lever(),
                              $urandom_range(0, 100000));
                default: set_config($urandom_range(0, 1) ? LEVER_MAX : LEVER_MIN,
                                    random_lever(),
                                    $urandom_range(0, 1) ? LEVER_MAX : LEVER_MIN,
                                    $urandom_range(0, 50));
            endcase
            steady_feed = (phase == 1) || (phase == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_pose(random_pose());
            end
            wait_idle();
        end
        steady_feed = 1'b0;
    endtask

    // The receiver holds off while samples keep coming, so the block fills up.
    task automatic test_backpressure();
        set_config(random_lever(), random_lever(), random_lever(), $urandom_range(0, 300));
        steady_feed = 1'b1;
        hold_request = 1'b1;
        for (int n = 0; n < 12; n++) begin
            send_pose(random_pose());
        end
        steady_feed = 1'b0;
        wait_idle();
        for (int n = 0; n < 12; n++) begin
            send_pose(random_pose());
        end
        wait_idle();
    endtask

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            if (rx_seg_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_seg_left = $urandom_range(30, 400);
            end
            rx_seg_left--;
            case (rx_mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_COIN:   i_ready <= ($urandom_range(0, 1) != 0);
                RX_MOSTLY: i_ready <= ($urandom_range(0, 7) != 0);
                default:   i_ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_com_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_com.size() == 0) begin
                $error("result transfer with no sample pending");
                errors++;
            end else begin
                want = pending_com.pop_front();
                compare_field("com_x", want.com_x, o_com_x);
                compare_field("com_y", want.com_y, o_com_y);
                compare_field("com_z", want.com_z, o_com_z);
                compare_field("rel_x", want.rel_x, o_rel_x);
                compare_field("rel_y", want.rel_y, o_rel_y);
                compare_field("rel_z", want.rel_z, o_rel_z);
                compare_field("rel_w", want.rel_w, o_rel_w);
                compare_field("forward", want.forward, o_forward);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_first_sample();
        test_rate_limit();
        test_extremes();
        test_random();
        test_backpressure();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_com.size() != 0) begin
            $error("%0d results never arrived", pending_com.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
